@@ rtl/core/scancode_to_char_translator_macros.svh @@
// Assertion macros for the translator RTL.
`ifndef SCANCODE_TO_CHAR_TRANSLATOR_MACROS_SVH
`define SCANCODE_TO_CHAR_TRANSLATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sct_pkg.sv @@
// Types, codes and key tables for the scancode translator.
package sct_pkg;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] character;
    logic       kbd_present;
    logic       enter_down;
  } out_item_t;

  typedef struct packed {
    logic shift_held;
    logic enter_flag;
    logic present_flag;
  } flags_t;

  localparam logic [7:0]  ABSENT_BYTE     = 8'hff;
  localparam logic [6:0]  KEY_LSHIFT      = 7'h2a;
  localparam logic [6:0]  KEY_RSHIFT      = 7'h36;
  localparam logic [6:0]  KEY_ENTER       = 7'h1c;
  localparam logic [7:0]  CODE_ENTER_BRK  = 8'h9c;
  localparam logic [6:0]  KEY_ALIAS_A     = 7'h73;
  localparam logic [6:0]  KEY_ALIAS_A_MAP = 7'h59;
  localparam logic [6:0]  KEY_ALIAS_B     = 7'h7d;
  localparam logic [6:0]  KEY_ALIAS_B_MAP = 7'h7c;
  localparam logic [11:0] VALUE_TAB       = 12'h009;
  localparam logic [7:0]  CHAR_SPACE      = 8'h20;
  localparam logic [7:0]  CHAR_CR         = 8'd13;

  localparam logic [15:0] ROM_PLAIN [128] = '{
    16'hf200, 16'hf01b, 16'hf031, 16'hf032, 16'hf033, 16'hf034, 16'hf035, 16'hf036,
    16'hf037, 16'hf038, 16'hf039, 16'hf030, 16'hf02d, 16'hf03d, 16'hf07f, 16'hf009,
    16'hfb71, 16'hfb77, 16'hfb65, 16'hfb72, 16'hfb74, 16'hfb79, 16'hfb75, 16'hfb69,
    16'hfb6f, 16'hfb70, 16'hf05b, 16'hf05d, 16'hf201, 16'hf702, 16'hfb61, 16'hfb73,
    16'hfb64, 16'hfb66, 16'hfb67, 16'hfb68, 16'hfb6a, 16'hfb6b, 16'hfb6c, 16'hf03b,
    16'hf027, 16'hf060, 16'hf700, 16'hf05c, 16'hfb7a, 16'hfb78, 16'hfb63, 16'hfb76,
    16'hfb62, 16'hfb6e, 16'hfb6d, 16'hf02c, 16'hf02e, 16'hf02f, 16'hf700, 16'hf30c,
    16'hf703, 16'hf020, 16'hf207, 16'hf100, 16'hf101, 16'hf102, 16'hf103, 16'hf104,
    16'hf105, 16'hf106, 16'hf107, 16'hf108, 16'hf109, 16'hf208, 16'hf209, 16'hf307,
    16'hf308, 16'hf309, 16'hf30b, 16'hf304, 16'hf305, 16'hf306, 16'hf30a, 16'hf301,
    16'hf302, 16'hf303, 16'hf300, 16'hf310, 16'hf206, 16'hf200, 16'hf03c, 16'hf10a,
    16'hf10b, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200,
    16'hf30e, 16'hf702, 16'hf30d, 16'hf01c, 16'hf701, 16'hf205, 16'hf114, 16'hf603,
    16'hf118, 16'hf601, 16'hf602, 16'hf117, 16'hf600, 16'hf119, 16'hf115, 16'hf116,
    16'hf11a, 16'hf10c, 16'hf10d, 16'hf11b, 16'hf11c, 16'hf110, 16'hf311, 16'hf11d,
    16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200
  };

  localparam logic [15:0] ROM_SHIFT [128] = '{
    16'hf200, 16'hf01b, 16'hf021, 16'hf040, 16'hf023, 16'hf024, 16'hf025, 16'hf05e,
    16'hf026, 16'hf02a, 16'hf028, 16'hf029, 16'hf05f, 16'hf02b, 16'hf07f, 16'hf009,
    16'hfb51, 16'hfb57, 16'hfb45, 16'hfb52, 16'hfb54, 16'hfb59, 16'hfb55, 16'hfb49,
    16'hfb4f, 16'hfb50, 16'hf07b, 16'hf07d, 16'hf201, 16'hf702, 16'hfb41, 16'hfb53,
    16'hfb44, 16'hfb46, 16'hfb47, 16'hfb48, 16'hfb4a, 16'hfb4b, 16'hfb4c, 16'hf03a,
    16'hf022, 16'hf07e, 16'hf700, 16'hf07c, 16'hfb5a, 16'hfb58, 16'hfb43, 16'hfb56,
    16'hfb42, 16'hfb4e, 16'hfb4d, 16'hf03c, 16'hf03e, 16'hf03f, 16'hf700, 16'hf30c,
    16'hf703, 16'hf020, 16'hf207, 16'hf10a, 16'hf10b, 16'hf10c, 16'hf10d, 16'hf10e,
    16'hf10f, 16'hf110, 16'hf111, 16'hf112, 16'hf113, 16'hf213, 16'hf203, 16'hf307,
    16'hf308, 16'hf309, 16'hf30b, 16'hf304, 16'hf305, 16'hf306, 16'hf30a, 16'hf301,
    16'hf302, 16'hf303, 16'hf300, 16'hf310, 16'hf206, 16'hf200, 16'hf03e, 16'hf10a,
    16'hf10b, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200,
    16'hf30e, 16'hf702, 16'hf30d, 16'hf200, 16'hf701, 16'hf205, 16'hf114, 16'hf603,
    16'hf20b, 16'hf601, 16'hf602, 16'hf117, 16'hf600, 16'hf20a, 16'hf115, 16'hf116,
    16'hf11a, 16'hf10c, 16'hf10d, 16'hf11b, 16'hf11c, 16'hf110, 16'hf311, 16'hf11d,
    16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200
  };

endpackage

@@ rtl/core/sct_in_stage.sv @@
// Input register stage: captures one scancode transaction at a time.
module sct_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_valid,
  output logic              key_ready,
  input  sct_pkg::in_item_t key_item,
  input  logic              advance,
  output logic              hold_valid,
  output sct_pkg::in_item_t hold_item
);

  logic vld;
  sct_pkg::in_item_t item;

  // Refill in the same cycle that the held transaction moves on.
  assign key_ready  = !vld || advance;
  assign hold_valid = vld;
  assign hold_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (key_ready) begin
      vld <= key_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_valid && key_ready) begin
      item <= key_item;
    end
  end

endmodule

@@ rtl/core/sct_xlate.sv @@
// Combinational translation of one held scancode into a result and new flags.
module sct_xlate (
  input  sct_pkg::in_item_t  item,
  input  sct_pkg::flags_t    flags,
  output sct_pkg::out_item_t result,
  output sct_pkg::flags_t    flags_next
);

  logic [6:0]  key;
  logic [6:0]  rom_key;
  logic [11:0] value;
  logic        brk;
  logic        absent;

  assign key    = item.data_byte[6:0];
  assign brk    = item.data_byte[7];
  assign absent = (item.status_byte == sct_pkg::ABSENT_BYTE) &&
                  (item.data_byte == sct_pkg::ABSENT_BYTE);

  always_comb begin
    if (key == sct_pkg::KEY_ALIAS_A) begin
      rom_key = sct_pkg::KEY_ALIAS_A_MAP;
    end else if (key == sct_pkg::KEY_ALIAS_B) begin
      rom_key = sct_pkg::KEY_ALIAS_B_MAP;
    end else begin
      rom_key = key;
    end
  end

  assign value = flags.shift_held ? sct_pkg::ROM_SHIFT[rom_key][11:0]
                                  : sct_pkg::ROM_PLAIN[rom_key][11:0];

  always_comb begin
    flags_next         = flags;
    result.char_valid  = 1'b0;
    result.character   = 8'd0;
    if (absent) begin
      flags_next.present_flag = 1'b0;
    end else begin
      flags_next.present_flag = 1'b1;
      if (key == sct_pkg::KEY_LSHIFT || key == sct_pkg::KEY_RSHIFT) begin
        flags_next.shift_held = !brk;
      end else if (brk) begin
        if (item.data_byte == sct_pkg::CODE_ENTER_BRK) begin
          flags_next.enter_flag = 1'b0;
        end
      end else begin
        result.char_valid = 1'b1;
        if (rom_key == sct_pkg::KEY_ENTER) begin
          flags_next.enter_flag = 1'b1;
          result.character      = sct_pkg::CHAR_CR;
        end else if (value == sct_pkg::VALUE_TAB) begin
          result.character = sct_pkg::CHAR_SPACE;
        end else begin
          result.character = value[7:0];
        end
      end
    end
    result.kbd_present = flags_next.present_flag;
    result.enter_down  = flags_next.enter_flag;
  end

endmodule

@@ rtl/core/sct_out_stage.sv @@
// Result register stage: holds one character transaction until it is taken.
module sct_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  sct_pkg::out_item_t load_item,
  output logic               free,
  output logic               chr_valid,
  input  logic               chr_ready,
  output sct_pkg::out_item_t chr_item
);

  logic vld;
  sct_pkg::out_item_t item;

  assign free      = !vld || chr_ready;
  assign chr_valid = vld;
  assign chr_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (free) begin
      vld <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      item <= load_item;
    end
  end

endmodule

@@ rtl/core/scancode_to_char_translator.sv @@
// Top level of the set-1 scancode to character translator.
//
//   Channel  Valid      Ready      Payload
//   input    key_valid  key_ready  key_item  (status_byte, data_byte)
//   output   chr_valid  chr_ready  chr_item  (char_valid, character, kbd_present, enter_down)
//
// Every input transaction yields one output transaction, registered in the input
// register and then the result register. One transaction per cycle is sustained while
// chr_ready is high; the table lookup sits between the two registers.
// Reset clears the shift, enter and present flags and both stage valids.
// A stall on the output backs up combinationally through the input register to key_ready.
`include "scancode_to_char_translator_macros.svh"

module scancode_to_char_translator (
  input  logic               clk,
  input  logic               rst,
  input  logic               key_valid,
  output logic               key_ready,
  input  sct_pkg::in_item_t  key_item,
  output logic               chr_valid,
  input  logic               chr_ready,
  output sct_pkg::out_item_t chr_item
);

  logic               hold_valid;
  sct_pkg::in_item_t  hold_item;
  logic               free;
  logic               advance;
  sct_pkg::out_item_t result;
  sct_pkg::flags_t    flags;
  sct_pkg::flags_t    flags_next;

  // The flags move only when the held transaction moves into the result register.
  assign advance = hold_valid && free;

  sct_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .key_item  (key_item),
    .advance   (advance),
    .hold_valid(hold_valid),
    .hold_item (hold_item)
  );

  sct_xlate u_xlate (
    .item      (hold_item),
    .flags     (flags),
    .result    (result),
    .flags_next(flags_next)
  );

  sct_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (hold_valid),
    .load_item (result),
    .free      (free),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr_item  (chr_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (advance) begin
      flags <= flags_next;
    end
  end

  `SCT_ASSERT_SAME(a_no_char_zero,
                   chr_valid && !chr_item.char_valid,
                   chr_item.character == 8'd0,
                   "character not zero without a valid character")
  `SCT_ASSERT_SAME(a_char_needs_kbd,
                   chr_valid && chr_item.char_valid,
                   chr_item.kbd_present,
                   "character produced with keyboard absent")
  `SCT_ASSERT_SAME(a_backpressure,
                   !key_ready,
                   hold_valid && chr_valid && !chr_ready,
                   "input stalled without a full pipeline")
  `SCT_ASSERT_NEXT(a_flags_hold,
                   chr_valid && !chr_ready,
                   $stable(flags),
                   "flags changed while the output was stalled")

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the set-1 scancode to character translator.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_REPORTS = 10;

  // Key maps kept apart from the package so that a wrong table entry shows up.
  localparam logic [15:0] PLAIN_KEYMAP [128] = '{
    16'hf200, 16'hf01b, 16'hf031, 16'hf032, 16'hf033, 16'hf034, 16'hf035, 16'hf036,
    16'hf037, 16'hf038, 16'hf039, 16'hf030, 16'hf02d, 16'hf03d, 16'hf07f, 16'hf009,
    16'hfb71, 16'hfb77, 16'hfb65, 16'hfb72, 16'hfb74, 16'hfb79, 16'hfb75, 16'hfb69,
    16'hfb6f, 16'hfb70, 16'hf05b, 16'hf05d, 16'hf201, 16'hf702, 16'hfb61, 16'hfb73,
    16'hfb64, 16'hfb66, 16'hfb67, 16'hfb68, 16'hfb6a, 16'hfb6b, 16'hfb6c, 16'hf03b,
    16'hf027, 16'hf060, 16'hf700, 16'hf05c, 16'hfb7a, 16'hfb78, 16'hfb63, 16'hfb76,
    16'hfb62, 16'hfb6e, 16'hfb6d, 16'hf02c, 16'hf02e, 16'hf02f, 16'hf700, 16'hf30c,
    16'hf703, 16'hf020, 16'hf207, 16'hf100, 16'hf101, 16'hf102, 16'hf103, 16'hf104,
    16'hf105, 16'hf106, 16'hf107, 16'hf108, 16'hf109, 16'hf208, 16'hf209, 16'hf307,
    16'hf308, 16'hf309, 16'hf30b, 16'hf304, 16'hf305, 16'hf306, 16'hf30a, 16'hf301,
    16'hf302, 16'hf303, 16'hf300, 16'hf310, 16'hf206, 16'hf200, 16'hf03c, 16'hf10a,
    16'hf10b, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200,
    16'hf30e, 16'hf702, 16'hf30d, 16'hf01c, 16'hf701, 16'hf205, 16'hf114, 16'hf603,
    16'hf118, 16'hf601, 16'hf602, 16'hf117, 16'hf600, 16'hf119, 16'hf115, 16'hf116,
    16'hf11a, 16'hf10c, 16'hf10d, 16'hf11b, 16'hf11c, 16'hf110, 16'hf311, 16'hf11d,
    16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200
  };

  localparam logic [15:0] SHIFT_KEYMAP [128] = '{
    16'hf200, 16'hf01b, 16'hf021, 16'hf040, 16'hf023, 16'hf024, 16'hf025, 16'hf05e,
    16'hf026, 16'hf02a, 16'hf028, 16'hf029, 16'hf05f, 16'hf02b, 16'hf07f, 16'hf009,
    16'hfb51, 16'hfb57, 16'hfb45, 16'hfb52, 16'hfb54, 16'hfb59, 16'hfb55, 16'hfb49,
    16'hfb4f, 16'hfb50, 16'hf07b, 16'hf07d, 16'hf201, 16'hf702, 16'hfb41, 16'hfb53,
    16'hfb44, 16'hfb46, 16'hfb47, 16'hfb48, 16'hfb4a, 16'hfb4b, 16'hfb4c, 16'hf03a,
    16'hf022, 16'hf07e, 16'hf700, 16'hf07c, 16'hfb5a, 16'hfb58, 16'hfb43, 16'hfb56,
    16'hfb42, 16'hfb4e, 16'hfb4d, 16'hf03c, 16'hf03e, 16'hf03f, 16'hf700, 16'hf30c,
    16'hf703, 16'hf020, 16'hf207, 16'hf10a, 16'hf10b, 16'hf10c, 16'hf10d, 16'hf10e,
    16'hf10f, 16'hf110, 16'hf111, 16'hf112, 16'hf113, 16'hf213, 16'hf203, 16'hf307,
    16'hf308, 16'hf309, 16'hf30b, 16'hf304, 16'hf305, 16'hf306, 16'hf30a, 16'hf301,
    16'hf302, 16'hf303, 16'hf300, 16'hf310, 16'hf206, 16'hf200, 16'hf03e, 16'hf10a,
    16'hf10b, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200,
    16'hf30e, 16'hf702, 16'hf30d, 16'hf200, 16'hf701, 16'hf205, 16'hf114, 16'hf603,
    16'hf20b, 16'hf601, 16'hf602, 16'hf117, 16'hf600, 16'hf20a, 16'hf115, 16'hf116,
    16'hf11a, 16'hf10c, 16'hf10d, 16'hf11b, 16'hf11c, 16'hf110, 16'hf311, 16'hf11d,
    16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200, 16'hf200
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               key_valid = 1'b0;
  logic               key_ready;
  sct_pkg::in_item_t  key_item = '0;
  logic               chr_valid;
  logic               chr_ready = 1'b0;
  sct_pkg::out_item_t chr_item;

  // Shadow keyboard state, advanced once per accepted key transaction.
  logic shift_down = 1'b0;
  logic enter_held = 1'b0;
  logic kbd_seen = 1'b0;

  sct_pkg::out_item_t pending_chars [$];

  int cycle_count = 0;
  int mismatches = 0;
  int keys_sent = 0;
  int chars_seen = 0;
  int absent_seen = 0;
  int input_stalls = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int hold_go = 0;

  scancode_to_char_translator uut (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .key_item  (key_item),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr_item  (chr_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_chars.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic sct_pkg::out_item_t translate_key(sct_pkg::in_item_t k);
    logic [6:0]         idx;
    logic [11:0]        value;
    sct_pkg::out_item_t r;
    r = '0;
    idx = k.data_byte[6:0];
    if (k.status_byte == sct_pkg::ABSENT_BYTE && k.data_byte == sct_pkg::ABSENT_BYTE) begin
      kbd_seen = 1'b0;
    end else begin
      kbd_seen = 1'b1;
      if (idx == sct_pkg::KEY_LSHIFT || idx == sct_pkg::KEY_RSHIFT) begin
        shift_down = ~k.data_byte[7];
      end else if (k.data_byte[7]) begin
        if (k.data_byte == sct_pkg::CODE_ENTER_BRK) begin
          enter_held = 1'b0;
        end
      end else begin
        if (idx == sct_pkg::KEY_ALIAS_A) begin
          idx = sct_pkg::KEY_ALIAS_A_MAP;
        end else if (idx == sct_pkg::KEY_ALIAS_B) begin
          idx = sct_pkg::KEY_ALIAS_B_MAP;
        end
        value = shift_down ? SHIFT_KEYMAP[idx][11:0] : PLAIN_KEYMAP[idx][11:0];
        if (value == sct_pkg::VALUE_TAB) begin
          value = {4'h0, sct_pkg::CHAR_SPACE};
        end
        r.char_valid = 1'b1;
        if (idx == sct_pkg::KEY_ENTER) begin
          enter_held = 1'b1;
          r.character = sct_pkg::CHAR_CR;
        end else begin
          r.character = value[7:0];
        end
      end
    end
    r.kbd_present = kbd_seen;
    r.enter_down = enter_held;
    return r;
  endfunction

  // Both channels are observed here at the rising edge, before the block updates.
  always @(posedge clk) begin
    sct_pkg::out_item_t want;
    if (!rst) begin
      if (key_valid && key_ready) begin
        pending_chars.push_back(translate_key(key_item));
        keys_sent++;
        if (key_item.status_byte == sct_pkg::ABSENT_BYTE
            && key_item.data_byte == sct_pkg::ABSENT_BYTE) begin
          absent_seen++;
        end
      end else if (key_valid) begin
        input_stalls++;
      end
      if (chr_valid && chr_ready) begin
        if (pending_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Unexpected result transaction at cycle %0d: %p", cycle_count, chr_item);
          end
        end else begin
          want = pending_chars.pop_front();
          if (chr_item.char_valid) begin
            chars_seen++;
          end
          if (chr_item.char_valid !== want.char_valid || chr_item.character !== want.character
              || chr_item.kbd_present !== want.kbd_present
              || chr_item.enter_down !== want.enter_down) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("Mismatch at cycle %0d: valid %b/%b char %h/%h present %b/%b enter %b/%b",
                       cycle_count, want.char_valid, chr_item.char_valid,
                       want.character, chr_item.character,
                       want.kbd_present, chr_item.kbd_present,
                       want.enter_down, chr_item.enter_down);
            end
          end
        end
      end
    end
  end

  // Output side: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    int hold_seen;
    int hold_left;
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      chr_ready <= 1'b0;
    end else begin
      chr_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_key(input sct_pkg::in_item_t k);
    while ($urandom_range(99) < send_idle_pct) begin
      key_valid <= 1'b0;
      @(negedge clk);
    end
    key_valid <= 1'b1;
    key_item <= k;
    @(posedge clk);
    while (!key_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_all_chars();
    key_valid <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  function automatic sct_pkg::in_item_t random_key();
    sct_pkg::in_item_t k;
    int pick;
    k.status_byte = 8'($urandom_range(255));
    k.data_byte = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 6) begin
      k.status_byte = sct_pkg::ABSENT_BYTE;
      k.data_byte = sct_pkg::ABSENT_BYTE;
    end else if (pick < 18) begin
      k.data_byte = {1'($urandom_range(1)),
                     ($urandom_range(1) ? sct_pkg::KEY_LSHIFT : sct_pkg::KEY_RSHIFT)};
    end else if (pick < 26) begin
      k.data_byte = {1'($urandom_range(1)), sct_pkg::KEY_ENTER};
    end else if (pick < 30) begin
      k.data_byte = {1'($urandom_range(1)),
                     ($urandom_range(1) ? sct_pkg::KEY_ALIAS_A : sct_pkg::KEY_ALIAS_B)};
    end else if (pick < 34) begin
      k.status_byte = sct_pkg::ABSENT_BYTE;
    end else if (pick < 38) begin
      k.data_byte = sct_pkg::ABSENT_BYTE;
    end else if (pick < 80) begin
      // Make codes dominate so that most transactions reach the key maps.
      k.data_byte[7] = 1'b0;
    end
    return k;
  endfunction

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_key({8'h00, 8'h00});
    send_key({sct_pkg::ABSENT_BYTE, sct_pkg::ABSENT_BYTE});
    send_key({sct_pkg::ABSENT_BYTE, 8'h1e});
    send_key({8'h00, sct_pkg::ABSENT_BYTE});
    send_key({8'h5a, 1'b0, sct_pkg::KEY_LSHIFT});
    send_key({8'ha5, 8'h1e});
    send_key({8'h00, 8'h02});
    send_key({8'h00, 8'h0f});
    send_key({8'h00, 1'b1, sct_pkg::KEY_LSHIFT});
    send_key({8'h00, 8'h0f});
    send_key({8'h00, 1'b0, sct_pkg::KEY_RSHIFT});
    send_key({8'h00, 1'b0, sct_pkg::KEY_ENTER});
    // An absent keyboard must leave the shift and enter flags alone.
    send_key({sct_pkg::ABSENT_BYTE, sct_pkg::ABSENT_BYTE});
    send_key({8'h00, 8'h35});
    send_key({8'h00, 1'b1, sct_pkg::KEY_RSHIFT});
    send_key({8'h00, 1'b0, sct_pkg::KEY_ALIAS_A});
    send_key({8'h00, 1'b0, sct_pkg::KEY_ALIAS_B});
    send_key({8'h00, 8'h9e});
    send_key({8'h00, sct_pkg::CODE_ENTER_BRK});
    send_key({8'h80, 8'h7f});
    send_key({8'h01, 1'b1, sct_pkg::KEY_ALIAS_A});
    send_key({8'h00, 8'h0e});
    send_key({sct_pkg::ABSENT_BYTE, 8'h02});
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_key(random_key());
  endtask

  // Hold the output off while keys keep coming, so the pipeline fills and stalls.
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 40;
    hold_go++;
    repeat (20) send_key(random_key());
  endtask

  task automatic test_sender_pause();
    wait_all_chars();
    repeat ($urandom_range(3, 10)) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random(100, 0, 0);
    test_random(100, 53, 0);
    test_sender_pause();
    test_random(100, 0, 53);
    test_output_hold();
    test_random(100, 25, 25);
    test_sender_pause();

    wait_all_chars();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", pending_chars.size());
    end
    $display("Sent %0d key transactions (%0d absent-keyboard), %0d characters produced.",
             keys_sent, absent_seen, chars_seen);
    $display("Input stalled %0d cycles; %0d mismatches in %0d cycles.",
             input_stalls, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
